[hdl/assert_macros.svh]
// -----------------------------------------------------------------------------
// assertion macros
// clocked concurrent checks with a synchronous reset disable
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// implication checked on every clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[hdl/sgr_pkg.sv]
// -----------------------------------------------------------------------------
// sgr_pkg
// shared widths, defaults and the span column lookup of the glyph row generator
// -----------------------------------------------------------------------------
package sgr_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 480;
  localparam int unsigned SCREEN_HEIGHT_DEF = 320;

  localparam int unsigned GLYPH_W  = 40;
  localparam int unsigned MASK_W   = 24;
  localparam int unsigned SCALE_W  = 3;
  localparam int unsigned GROW_W   = 3;
  localparam int unsigned GLYPH_COLS = 5;
  localparam int unsigned GLYPH_ROWS = 7;

  typedef logic [SCALE_W-1:0] scale_t;
  typedef logic [GROW_W-1:0]  grow_t;

  // glyph column under span pixel gx at scale sc (1..4), by reciprocal for three
  function automatic logic [4:0] col_for(input int unsigned gx, input scale_t sc);
    logic [9:0] g;
    logic [9:0] c;
    g = 10'(gx);
    case (sc)
      3'd1:    c = g;
      3'd2:    c = g >> 1;
      3'd3:    c = (g * 10'd11) >> 5;
      default: c = g >> 2;
    endcase
    return c[4:0];
  endfunction

endpackage

[hdl/sgr_mask.sv]
// -----------------------------------------------------------------------------
// sgr_mask
// builds the on-mask of one cell row from the glyph columns and the scale
// -----------------------------------------------------------------------------
module sgr_mask (
  input  logic [sgr_pkg::GLYPH_W-1:0] glyph,
  input  sgr_pkg::grow_t              grow,
  input  sgr_pkg::scale_t             scale,
  output logic [sgr_pkg::MASK_W-1:0]  mask
);
  import sgr_pkg::*;

  logic [GLYPH_COLS-1:0] row_bits;

  // one bit per glyph column for this glyph row, row seven is blank
  always_comb begin
    for (int c = 0; c < GLYPH_COLS; c++) begin
      row_bits[c] = glyph[c*8 + int'(grow)] && (grow != grow_t'(GLYPH_ROWS));
    end
  end

  // replicate columns by the scale, column five and beyond stay clear
  always_comb begin
    logic [4:0] col;
    for (int gx = 0; gx < MASK_W; gx++) begin
      col = col_for(gx, scale);
      mask[gx] = (col < 5'(GLYPH_COLS)) ? row_bits[col[2:0]] : 1'b0;
    end
  end

endmodule

[hdl/scaled_glyph_row_generator_core.sv]
// -----------------------------------------------------------------------------
// scaled_glyph_row_generator_core
// turns one character word into one framebuffer span word per cell row
// -----------------------------------------------------------------------------
// A character passes three set-up steps (latch, bounds check with the row
// base multiply, column add) and then gives one cell row per cycle while the
// output is not stalled, 8*scale rows; a dropped character leaves after the
// bounds check. The row loop steps the framebuffer index through one shared
// adder that adds the column origin once and then the screen width per row.
// The next character is taken once the last row sits in the output register.
module scaled_glyph_row_generator_core #(
  parameter int unsigned SCREEN_WIDTH  = sgr_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = sgr_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic                        first_of_string,
  input  logic signed [15:0]          start_x,
  input  logic signed [15:0]          start_y,
  input  logic [2:0]                  scale,
  input  logic [15:0]                 fg_color,
  input  logic [15:0]                 bg_color,
  input  logic                        transparent,
  input  logic [sgr_pkg::GLYPH_W-1:0] glyph_columns,
  output logic                        row_valid,
  input  logic                        row_stall,
  output logic [17:0]                 pixel_index,
  output logic [4:0]                  span_width,
  output logic [sgr_pkg::MASK_W-1:0]  on_mask,
  output logic [15:0]                 fore_value,
  output logic [15:0]                 back_value,
  output logic                        write_background,
  output logic                        last_row
);
  import sgr_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned SW_BITS = $clog2(SCREEN_WIDTH + 1);
  localparam int unsigned PROD_W  = 16 + SW_BITS;
  localparam logic [SW_BITS-1:0] SW_U = SW_BITS'(SCREEN_WIDTH);
  localparam logic signed [17:0] SW_S = 18'(SCREEN_WIDTH);
  localparam logic signed [17:0] SH_S = 18'(SCREEN_HEIGHT);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_BASE  = 2'd2;
  localparam logic [1:0] ST_ROWS  = 2'd3;

  logic [1:0]               state;
  logic signed [15:0]       cursor_col;
  logic signed [15:0]       top_row;
  scale_t                   held_scale;
  logic [15:0]              held_fore;
  logic [15:0]              held_back;
  logic                     held_transparent;
  logic                     string_stopped;
  logic [GLYPH_W-1:0]       glyph;
  logic [17:0]              idx;
  logic [4:0]               row_cnt;
  logic [1:0]               rep_cnt;
  grow_t                    grow;

  logic [4:0]               cell_w;
  logic [4:0]               h_last;
  logic signed [17:0]       col_end;
  logic signed [17:0]       row_end;
  logic                     off_screen;
  logic [PROD_W-1:0]        base_prod;
  logic [17:0]              add_op;
  logic [17:0]              add_sum;
  logic [MASK_W-1:0]        mask_w;
  logic                     item_take;
  logic                     row_load;
  scale_t                   sc_clamped;

  assign item_stall = (state != ST_IDLE);
  assign item_take  = item_valid && !item_stall;
  assign row_load   = !row_valid || !row_stall;

  // cell geometry
  assign cell_w = 5'(held_scale) * 5'd6;
  assign h_last = 5'({held_scale, 3'b000} - 6'd1);

  // bounds of the cell against the screen
  assign col_end    = 18'(cursor_col) + 18'(cell_w);
  assign row_end    = 18'(top_row) + 18'({held_scale, 3'b000});
  assign off_screen = cursor_col[15] || top_row[15] || (col_end > SW_S) || (row_end > SH_S);

  // row base of the cell
  assign base_prod = PROD_W'(top_row[15:0]) * PROD_W'(SW_U);

  // shared index adder: column origin once, then one screen width per row
  assign add_op  = (state == ST_BASE) ? 18'(cursor_col[15:0]) : 18'(SCREEN_WIDTH);
  assign add_sum = idx + add_op;

  // requested scale clamped to one..four
  always_comb begin
    if (scale == 3'd0) begin
      sc_clamped = 3'd1;
    end else if (scale > 3'd4) begin
      sc_clamped = 3'd4;
    end else begin
      sc_clamped = scale;
    end
  end

  sgr_mask u_mask (
    .glyph (glyph),
    .grow  (grow),
    .scale (held_scale),
    .mask  (mask_w)
  );

  // sequencer and string state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      cursor_col       <= '0;
      top_row          <= '0;
      held_scale       <= 3'd1;
      held_fore        <= '0;
      held_back        <= '0;
      held_transparent <= 1'b0;
      string_stopped   <= 1'b1;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (item_take) begin
            if (first_of_string) begin
              cursor_col       <= start_x;
              top_row          <= start_y;
              held_scale       <= sc_clamped;
              held_fore        <= fg_color;
              held_back        <= bg_color;
              held_transparent <= transparent;
              string_stopped   <= 1'b0;
            end
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (string_stopped) begin
            state <= ST_IDLE;
          end else if (off_screen) begin
            string_stopped <= 1'b1;
            state          <= ST_IDLE;
          end else begin
            state <= ST_BASE;
          end
        end
        ST_BASE: begin
          state <= ST_ROWS;
        end
        ST_ROWS: begin
          if (row_load && (row_cnt == h_last)) begin
            cursor_col <= cursor_col + 16'(cell_w);
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // glyph word, index and row counters
  always_ff @(posedge clk) begin
    if (item_take) begin
      glyph <= glyph_columns;
    end
    if (state == ST_CHECK) begin
      idx <= base_prod[17:0];
    end else if (state == ST_BASE || (state == ST_ROWS && row_load)) begin
      idx <= add_sum;
    end
    if (state == ST_BASE) begin
      row_cnt <= '0;
      rep_cnt <= '0;
      grow    <= '0;
    end else if (state == ST_ROWS && row_load) begin
      row_cnt <= row_cnt + 5'd1;
      if (rep_cnt == 2'(held_scale - 3'd1)) begin
        rep_cnt <= '0;
        grow    <= grow + grow_t'(1);
      end else begin
        rep_cnt <= rep_cnt + 2'd1;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= 1'b0;
    end else if (state == ST_ROWS && row_load) begin
      row_valid <= 1'b1;
    end else if (!row_stall) begin
      row_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_ROWS && row_load) begin
      pixel_index      <= idx;
      span_width       <= cell_w;
      on_mask          <= mask_w;
      fore_value       <= held_fore;
      back_value       <= held_transparent ? 16'd0 : held_back;
      write_background <= !held_transparent;
      last_row         <= (row_cnt == h_last);
    end
  end

  // checks
  `ASSERT_NEXT(a_busy_after_take, clk, rst, item_take, item_stall)
  `ASSERT_IMPLY(a_span_legal, clk, rst, row_valid,
                span_width == 5'd6 || span_width == 5'd12 ||
                span_width == 5'd18 || span_width == 5'd24)
  `ASSERT_IMPLY(a_rows_live_string, clk, rst, state == ST_ROWS, !string_stopped)
  `ASSERT_IMPLY(a_back_cleared, clk, rst, row_valid && !write_background,
                back_value == 16'd0)

endmodule
